// File: rtl/core/iom_pkg.sv
// integral occupancy map: shared types, constants and sequencer states
// no dependencies

package iom_pkg;

  localparam int MaxRows  = 256;
  localparam int MaxCols  = 256;
  localparam int SumWidth = 32;
  localparam int RowBits  = $clog2(MaxRows);
  localparam int ColBits  = $clog2(MaxCols);
  localparam int AddrBits = RowBits + ColBits;
  localparam int SizeBits = 9;
  localparam int CntBits  = 17;

  typedef logic [SumWidth-1:0] sum_t;

  typedef enum logic [1:0] {
    REQ_BEGIN = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] row_origin;
    logic [7:0] col_origin;
    logic [7:0] pixel_value;
    logic [8:0] win_rows;
    logic [8:0] win_cols;
    logic [31:0] rand_word;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  hit_row;
    logic [7:0]  hit_col;
    logic [16:0] free_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PIX_RD,
    ST_PIX_ACC,
    ST_PIX_WR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_Q_TEST,
    ST_Q_GOAL0,
    ST_Q_GOAL1,
    ST_OUT
  } state_t;

  // accumulator command to the shared add unit
  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } acc_cmd_t;

endpackage

// File: rtl/core/integral_occupancy_map_core.sv
// integral occupancy map top level: sequencer, table memory, shared accumulator
// uses iom_pkg, iom_table_ram, iom_acc
// after reset a clearing pass zeroes the table; no item is taken then
// a pixel item makes three reads (left, up, up-left) through one port
// a query scans its window corners up to twice (counting, then picking), four reads
// per corner, with the goal product formed between the two scans;
// the single table read port sets the rate; reset (sync, active low) opens a region at 0,0

module integral_occupancy_map_core import iom_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [8:0] cfg_data
);

  state_t state_r, state_nxt;

  // configuration
  logic [SizeBits-1:0] rows_r, cols_r;
  logic [SizeBits-1:0] cfg_sat;
  logic [SizeBits-1:0] cfg_max;

  // region cursor
  logic [RowBits-1:0] cur_row_r, cur_row_nxt;
  logic [ColBits-1:0] cur_col_r, cur_col_nxt;
  logic [ColBits-1:0] col_start_r, col_start_nxt;
  logic               open_r, open_nxt;

  // captured item
  in_item_t item_r, item_nxt;

  // scan state
  logic [RowBits-1:0] qi_r, qi_nxt;
  logic [ColBits-1:0] qj_r, qj_nxt;
  logic [2:0]         step_r, step_nxt;   // read or term index
  logic               pass_r, pass_nxt;   // 0 counting, 1 picking
  logic [CntBits-1:0] hits_r, hits_nxt;
  logic [CntBits-1:0] seen_r, seen_nxt;
  logic [CntBits-1:0] goal_r, goal_nxt;
  logic [48:0]        prod_r, prod_nxt;
  logic [AddrBits:0]  clr_r, clr_nxt;
  logic [SizeBits-1:0] row_lim, col_lim;
  logic               rd_zero_r, rd_zero_nxt;  // current read is outside the image
  logic               term_sub_r, term_sub_nxt;

  out_item_t res_r, res_nxt;
  logic      out_valid_r, out_valid_nxt;

  // memory and accumulator hookup
  logic                we;
  logic [AddrBits-1:0] waddr, raddr;
  sum_t                wdata, rdata, acc;
  acc_cmd_t            cmd;
  sum_t                operand;

  iom_table_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  iom_acc u_acc (
    .clk     (clk),
    .cmd     (cmd),
    .operand (operand),
    .acc     (acc)
  );

  // config saturates to 1..max of the addressed dimension
  assign cfg_max = (cfg_index == CFG_ROWS) ? SizeBits'(MaxRows) : SizeBits'(MaxCols);

  always_comb begin
    if (cfg_data == '0) begin
      cfg_sat = SizeBits'(1);
    end else if (cfg_data > cfg_max) begin
      cfg_sat = cfg_max;
    end else begin
      cfg_sat = cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SizeBits'(MaxRows);
      cols_r <= SizeBits'(MaxCols);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROWS) begin
        rows_r <= cfg_sat;
      end else begin
        rows_r <= rows_r;
        cols_r <= cfg_sat;
      end
    end
  end

  // window limits: corner count per row and column
  assign row_lim = (item_r.win_rows < rows_r) ? rows_r - item_r.win_rows : '0;
  assign col_lim = (item_r.win_cols < cols_r) ? cols_r - item_r.win_cols : '0;

  // row/column sums for the corner reads (9 bits plus carry)
  logic [SizeBits:0] rsum, csum;
  assign rsum = {2'b0, qi_r} + {1'b0, item_r.win_rows};
  assign csum = {2'b0, qj_r} + {1'b0, item_r.win_cols};

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      col_start_r <= '0;
      open_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      col_start_r <= col_start_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    qi_r       <= qi_nxt;
    qj_r       <= qj_nxt;
    step_r     <= step_nxt;
    pass_r     <= pass_nxt;
    hits_r     <= hits_nxt;
    seen_r     <= seen_nxt;
    goal_r     <= goal_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    rd_zero_r  <= rd_zero_nxt;
    term_sub_r <= term_sub_nxt;
  end

  // sequencer
  always_comb begin
    logic last_j, last_i;
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    col_start_nxt = col_start_r;
    open_nxt      = open_r;
    out_valid_nxt = out_valid_r;
    item_nxt      = item_r;
    qi_nxt        = qi_r;
    qj_nxt        = qj_r;
    step_nxt      = step_r;
    pass_nxt      = pass_r;
    hits_nxt      = hits_r;
    seen_nxt      = seen_r;
    goal_nxt      = goal_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    rd_zero_nxt   = 1'b1;
    term_sub_nxt  = 1'b0;
    we            = 1'b0;
    waddr         = {cur_row_r, cur_col_r};
    wdata         = acc;
    raddr         = '0;
    cmd           = '0;
    operand       = rd_zero_r ? '0 : rdata;
    last_j        = ({1'b0, qj_r} + 1'b1) >= col_lim;
    last_i        = ({1'b0, qi_r} + 1'b1) >= row_lim;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r[AddrBits-1:0];
        wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r[AddrBits-1:0] == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          item_nxt = in_data;
          case (in_data.req_type)
            REQ_BEGIN: begin
              cur_row_nxt   = in_data.row_origin;
              cur_col_nxt   = in_data.col_origin;
              col_start_nxt = in_data.col_origin;
              open_nxt      = ({1'b0, in_data.row_origin} < rows_r) &&
                              ({1'b0, in_data.col_origin} < cols_r);
            end
            REQ_PIXEL: begin
              if (open_r) begin
                if ({1'b0, cur_row_r} >= rows_r || {1'b0, cur_col_r} >= cols_r) begin
                  open_nxt = 1'b0;
                end else begin
                  state_nxt = ST_PIX_RD;
                  step_nxt  = '0;
                end
              end
            end
            REQ_QUERY: begin
              state_nxt = ST_Q_RD;
              qi_nxt    = '0;
              qj_nxt    = '0;
              step_nxt  = '0;
              pass_nxt  = 1'b0;
              hits_nxt  = '0;
              seen_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      // pixel: reads left, up, up-left one per cycle; accumulate behind the read
      ST_PIX_RD: begin
        cmd.clear = (step_r == 3'd0);
        if (step_r != 3'd0) begin
          cmd.add = (step_r != 3'd3);
          cmd.sub = (step_r == 3'd3);
        end
        case (step_r)
          3'd0: begin
            raddr       = {cur_row_r, cur_col_r - 1'b1};
            rd_zero_nxt = (cur_col_r == '0);
          end
          3'd1: begin
            raddr       = {cur_row_r - 1'b1, cur_col_r};
            rd_zero_nxt = (cur_row_r == '0);
          end
          3'd2: begin
            raddr       = {cur_row_r - 1'b1, cur_col_r - 1'b1};
            rd_zero_nxt = (cur_row_r == '0) || (cur_col_r == '0);
          end
          default: ;
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == 3'd3) begin
          state_nxt = ST_PIX_ACC;
        end
      end
      ST_PIX_ACC: begin
        cmd.add = 1'b1;
        operand = {{(SumWidth-8){1'b0}}, item_r.pixel_value};
        state_nxt = ST_PIX_WR;
      end
      ST_PIX_WR: begin
        we = 1'b1;
        state_nxt = ST_IDLE;
        if ({1'b0, cur_col_r} + 1'b1 < cols_r) begin
          cur_col_nxt = cur_col_r + 1'b1;
        end else begin
          cur_col_nxt = col_start_r;
          if ({1'b0, cur_row_r} + 1'b1 < rows_r) begin
            cur_row_nxt = cur_row_r + 1'b1;
          end else begin
            open_nxt = 1'b0;
          end
        end
      end
      // query: four corner reads, each summed into the accumulator in the cycle after its read
      ST_Q_RD: begin
        if (row_lim == '0 || col_lim == '0) begin
          state_nxt = ST_Q_GOAL0;
        end else begin
          cmd.clear = (step_r == 3'd0);
          if (step_r != 3'd0) begin
            cmd.add = !term_sub_r;
            cmd.sub = term_sub_r;
          end
          case (step_r)
            3'd0: begin
              raddr        = {qi_r, qj_r};
              rd_zero_nxt  = 1'b0;
            end
            3'd1: begin
              raddr        = {rsum[RowBits-1:0], csum[ColBits-1:0]};
              rd_zero_nxt  = rsum >= (SizeBits+1)'(MaxRows) ||
                             csum >= (SizeBits+1)'(MaxCols);
            end
            3'd2: begin
              raddr        = {rsum[RowBits-1:0], qj_r};
              rd_zero_nxt  = rsum >= (SizeBits+1)'(MaxRows);
              term_sub_nxt = 1'b1;
            end
            3'd3: begin
              raddr        = {qi_r, csum[ColBits-1:0]};
              rd_zero_nxt  = csum >= (SizeBits+1)'(MaxCols);
              term_sub_nxt = 1'b1;
            end
            default: ;
          endcase
          step_nxt = step_r + 1'b1;
          if (step_r == 3'd4) begin
            state_nxt = ST_Q_TEST;
          end
        end
      end
      ST_Q_TEST: begin
        step_nxt  = '0;
        state_nxt = ST_Q_RD;
        if (acc == '0) begin
          if (!pass_r) begin
            hits_nxt = hits_r + 1'b1;
          end else if (seen_r == goal_r) begin
            res_nxt.found   = 1'b1;
            res_nxt.hit_row = qi_r;
            res_nxt.hit_col = qj_r;
            state_nxt       = ST_OUT;
          end else begin
            seen_nxt = seen_r + 1'b1;
          end
        end
        if (state_nxt != ST_OUT) begin
          if (last_j) begin
            qj_nxt = '0;
            if (last_i) begin
              qi_nxt    = '0;
              state_nxt = pass_r ? ST_OUT : ST_Q_GOAL0;
            end else begin
              qi_nxt = qi_r + 1'b1;
            end
          end else begin
            qj_nxt = qj_r + 1'b1;
          end
        end
      end
      ST_Q_GOAL0: begin
        prod_nxt  = {17'd0, item_r.rand_word} * {32'd0, hits_r};
        state_nxt = ST_Q_GOAL1;
      end
      ST_Q_GOAL1: begin
        goal_nxt = prod_r[48:32];
        res_nxt  = '0;
        res_nxt.free_count = hits_r;
        if (hits_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          pass_nxt  = 1'b1;
          step_nxt  = '0;
          state_nxt = ST_Q_RD;
        end
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/iom_table_ram.sv
// summed-area table storage: one write port, one registered read port
// uses iom_pkg

module iom_table_ram import iom_pkg::*; (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  sum_t                wdata,
  input  logic [AddrBits-1:0] raddr,
  output sum_t                rdata
);

  sum_t mem [2**AddrBits];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/iom_acc.sv
// shared add/subtract accumulator used for pixel sums and corner sums
// uses iom_pkg

module iom_acc import iom_pkg::*; (
  input  logic     clk,
  input  acc_cmd_t cmd,
  input  sum_t     operand,
  output sum_t     acc
);

  sum_t acc_r, acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.clear) begin
      acc_nxt = '0;
    end
    if (cmd.add) begin
      acc_nxt = acc_nxt + operand;
    end else if (cmd.sub) begin
      acc_nxt = acc_nxt - operand;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: rtl/core/iom_checker.sv
// port-level checks for the integral occupancy map core
// uses iom_pkg; bound to integral_occupancy_map_core

module iom_checker import iom_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");

  a_no_take_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.hit_row == '0 && out_data.hit_col == '0)
    else $error("not-found result with nonzero corner");

  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> out_data.free_count != '0)
    else $error("found with zero count");

endmodule

bind integral_occupancy_map_core iom_checker u_iom_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/integral_occupancy_map_core_test.sv
// testbench for integral_occupancy_map_core: directed stimulus rows, then random region
// builds and window queries, each result checked against an in-bench summed-area predictor
// or against the result given with its directed row; depends on iom_pkg and the core rtl

module integral_occupancy_map_core_test;
  import iom_pkg::*;

  localparam int WatchLimit = 400000;  // covers the clearing pass and the slowest query used
  localparam int SettleCycles = 60;    // longer than a pixel item takes inside the block
  localparam int HoldCycles = 3000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_ROWS;
  logic [8:0] cfg_data = '0;

  integral_occupancy_map_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // predictor state: summed-area table, cursor and image size
  logic [31:0] sat_mem [MaxRows*MaxCols];
  int unsigned img_rows, img_cols;
  int unsigned cur_row, cur_col, reg_col0;
  bit          reg_open;

  out_item_t window_q[$];  // results still to come, oldest first
  int        n_errors = 0;
  bit        quiet = 1'b0;   // no idling on either side
  bit        hold_go = 1'b0; // ask the receiver for one long hold-off
  bit        hold_done = 1'b0;
  int        hold_left = 0;
  int        quiet_cycles = 0;

  function automatic logic [31:0] sat_rd(int unsigned r, int unsigned c);
    if (r >= MaxRows || c >= MaxCols) return '0;
    return sat_mem[r*MaxCols + c];
  endfunction

  function automatic int unsigned clamp_size(logic [8:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void map_config(logic idx, logic [8:0] val);
    if (idx == CFG_ROWS) img_rows = clamp_size(val, MaxRows);
    else img_cols = clamp_size(val, MaxCols);
  endfunction

  function automatic logic [31:0] corner(int unsigned i, int unsigned j,
                                         int unsigned h, int unsigned w);
    return sat_rd(i, j) + sat_rd(i+h, j+w) - sat_rd(i+h, j) - sat_rd(i, j+w);
  endfunction

  // advances the map by one item; returns 1 when the item yields a result
  function automatic bit map_step(in_item_t it, output out_item_t res);
    int unsigned r, c, h, w, row_lim, col_lim, hits, seen;
    logic [31:0] v;
    logic [63:0] prod;
    res = '0;
    case (req_t'(it.req_type))
      REQ_BEGIN: begin
        cur_row = it.row_origin;
        cur_col = it.col_origin;
        reg_col0 = cur_col;
        reg_open = cur_row < img_rows && cur_col < img_cols;
        return 1'b0;
      end
      REQ_PIXEL: begin
        r = cur_row;
        c = cur_col;
        if (!reg_open) return 1'b0;
        // cursor outside a shrunk image closes the region
        if (r >= img_rows || c >= img_cols) begin
          reg_open = 1'b0;
          return 1'b0;
        end
        v = it.pixel_value;
        if (c > 0) v += sat_rd(r, c-1);
        if (r > 0) v += sat_rd(r-1, c);
        if (r > 0 && c > 0) v -= sat_rd(r-1, c-1);
        sat_mem[r*MaxCols + c] = v;
        if (c + 1 < img_cols) begin
          cur_col = c + 1;
        end else begin
          cur_col = reg_col0;
          if (r + 1 < img_rows) cur_row = r + 1;
          else reg_open = 1'b0;
        end
        return 1'b0;
      end
      REQ_QUERY: begin
        h = it.win_rows;
        w = it.win_cols;
        row_lim = (h < img_rows) ? img_rows - h : 0;
        col_lim = (w < img_cols) ? img_cols - w : 0;
        hits = 0;
        for (int i = 0; i < row_lim; i++)
          for (int j = 0; j < col_lim; j++)
            if (corner(i, j, h, w) == 0) hits++;
        if (hits == 0) return 1'b1;
        res.free_count = hits[16:0];
        prod = {32'd0, it.rand_word} * 64'(hits);
        seen = 0;
        for (int i = 0; i < row_lim; i++)
          for (int j = 0; j < col_lim; j++)
            if (corner(i, j, h, w) == 0) begin
              if (seen == prod[63:32] && !res.found) begin
                res.found = 1'b1;
                res.hit_row = i[7:0];
                res.hit_col = j[7:0];
              end
              seen++;
            end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // result side: check every transfer, random stalls, one long hold-off
  always @(posedge clk) begin
    out_item_t w;
    if (out_valid && out_ready) begin
      if (window_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        w = window_q.pop_front();
        if (out_data.found !== w.found) report("found", out_data.found, w.found);
        if (out_data.hit_row !== w.hit_row) report("hit_row", out_data.hit_row, w.hit_row);
        if (out_data.hit_col !== w.hit_col) report("hit_col", out_data.hit_col, w.hit_col);
        if (out_data.free_count !== w.free_count)
          report("free_count", out_data.free_count, w.free_count);
      end
    end
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 26);
    end
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // append a result to the expected queue
  function automatic void expect_result(out_item_t r);
    window_q = {window_q, r};
  endfunction

  // offer one item, predict it at its transfer; valid stays high on exit
  task automatic send_item(in_item_t it, bit typed = 1'b0, out_item_t typed_res = '0);
    out_item_t res;
    if (!quiet && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (map_step(it, res)) expect_result(typed ? typed_res : res);
  endtask

  // let the block go idle before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    map_config(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_item_t mk(req_t kind, int ro = 0, int co = 0, int pv = 0,
                                  int wr = 0, int wc = 0, logic [31:0] rw = 0);
    in_item_t it;
    it.req_type = kind;
    it.row_origin = ro[7:0];
    it.col_origin = co[7:0];
    it.pixel_value = pv[7:0];
    it.win_rows = wr[8:0];
    it.win_cols = wc[8:0];
    it.rand_word = rw;
    return it;
  endfunction

  typedef struct {
    bit        is_cfg;
    logic      idx;
    logic [8:0] val;
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function automatic void row_item(in_item_t it, bit typed = 1'b0, out_item_t res = '0);
    stim_row_t row;
    row = '{1'b0, CFG_ROWS, 9'd0, it, typed, res};
    stim_rows = {stim_rows, row};
  endfunction

  function automatic void row_cfg(logic idx, logic [8:0] val);
    stim_row_t row;
    row = '{1'b1, idx, val, '0, 1'b0, '0};
    stim_rows = {stim_rows, row};
  endfunction

  typedef bit bool_big_t;

  function automatic in_item_t rand_query(bool_big_t big);
    int h, w;
    logic [31:0] rw;
    case ($urandom_range(9))
      0: rw = '0;
      1: rw = '1;
      default: rw = $urandom;
    endcase
    if (big) begin
      // full-size image: keep the corner count small
      h = $urandom_range(240, 256);
      w = $urandom_range(240, 256);
    end else begin
      h = ($urandom_range(9) == 0) ? 256 : $urandom_range(0, img_rows);
      w = ($urandom_range(9) == 0) ? 256 : $urandom_range(0, img_cols);
    end
    return mk(REQ_QUERY, $urandom, $urandom, $urandom, h, w, rw);
  endfunction

  initial begin
    int n_sent;
    int ro, co, npix;
    bit big;
    in_item_t it;

    sat_mem = '{default: '0};
    img_rows = MaxRows;
    img_cols = MaxCols;
    cur_row = 0;
    cur_col = 0;
    reg_col0 = 0;
    reg_open = 1'b1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows: cleared table at full size first
    row_item(mk(REQ_QUERY, 0, 0, 0, 256, 256, '1), 1'b1, '0);
    row_item(mk(REQ_QUERY, 0, 0, 0, 255, 255, '1), 1'b1, '{1'b1, 8'd0, 8'd0, 17'd1});
    row_item(mk(REQ_QUERY, 0, 0, 0, 256, 0, '0), 1'b1, '0);
    row_item(mk(REQ_NONE, 255, 255, 255, 511, 511, '1));
    // out-of-range register values saturate
    row_cfg(CFG_ROWS, 9'd0);
    row_cfg(CFG_COLS, 9'd511);
    row_item(mk(REQ_QUERY, 0, 0, 0, 0, 0, '1), 1'b1, '{1'b1, 8'd0, 8'd255, 17'd256});
    // small image, full build, then a finished region
    row_cfg(CFG_ROWS, 9'd3);
    row_cfg(CFG_COLS, 9'd3);
    row_item(mk(REQ_BEGIN, 0, 0));
    row_item(mk(REQ_PIXEL, 0, 0, 255));
    repeat (7) row_item(mk(REQ_PIXEL, 0, 0, 0));
    row_item(mk(REQ_PIXEL, 0, 0, 255));
    row_item(mk(REQ_PIXEL, 0, 0, 255));
    row_item(mk(REQ_QUERY, 0, 0, 0, 0, 0, '0));
    row_item(mk(REQ_QUERY, 0, 0, 0, 1, 1, 32'h8000_0000));
    row_item(mk(REQ_QUERY, 0, 0, 0, 2, 2, '0));
    // begin outside the image, pixels ignored
    row_item(mk(REQ_BEGIN, 200, 3));
    row_item(mk(REQ_PIXEL, 0, 0, 7));
    // partial region left open, then the image shrinks under its cursor
    row_item(mk(REQ_BEGIN, 1, 2));
    row_item(mk(REQ_PIXEL, 0, 0, 255));
    row_cfg(CFG_COLS, 9'd2);
    row_item(mk(REQ_PIXEL, 0, 0, 255));
    row_item(mk(REQ_QUERY, 0, 0, 0, 1, 0, '1));
    row_cfg(CFG_COLS, 9'd3);
    row_item(mk(REQ_PIXEL, 0, 0, 255));
    row_item(mk(REQ_QUERY, 0, 0, 0, 0, 1, $urandom));

    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_cfg) begin
        drain();
        write_reg(stim_rows[k].idx, stim_rows[k].val);
      end else begin
        send_item(stim_rows[k].it, stim_rows[k].typed, stim_rows[k].res);
      end
    end

    // random phases: new image size, then region builds with queries
    n_sent = 0;
    for (int ph = 0; ph < 5 || n_sent < 70; ph++) begin
      drain();
      big = (ph == 1);
      if (big) begin
        write_reg(CFG_ROWS, 9'd256);
        write_reg(CFG_COLS, 9'd256);
      end else if (ph == 2) begin
        write_reg(CFG_COLS, 9'd1);
        write_reg(CFG_ROWS, 9'd1);
      end else begin
        write_reg(CFG_ROWS, 9'($urandom_range(2, 4)));
        write_reg(CFG_COLS, 9'($urandom_range(2, 4)));
      end
      quiet = (ph == 4);
      if (ph == 3) hold_go = 1'b1;
      repeat ($urandom_range(1, 3)) begin
        if (ph == 3 || $urandom_range(99) < 75) begin
          // well-formed region: begin inside the image, pixels to its end (or 0 to one past it)
          if (big) begin
            ro = $urandom_range(252, 255);
            co = $urandom_range(252, 255);
          end else begin
            ro = $urandom_range(0, img_rows - 1);
            co = $urandom_range(0, img_cols - 1);
          end
          send_item(mk(REQ_BEGIN, ro, co, $urandom, $urandom, $urandom, $urandom));
          npix = (img_rows - ro) * (img_cols - co);
          if ($urandom_range(99) < 20) npix = $urandom_range(0, npix + 1);
          repeat (npix) begin
            it = mk(REQ_PIXEL, $urandom, $urandom, 0, $urandom, $urandom, $urandom);
            case ($urandom_range(9))
              0, 1: it.pixel_value = 8'd255;
              2: it.pixel_value = $urandom;
              default: it.pixel_value = 8'd0;
            endcase
            send_item(it);
          end
          n_sent += npix + 1;
          repeat ($urandom_range(1, 3)) begin
            send_item(rand_query(big));
            n_sent++;
          end
        end else begin
          // noise: unused type, stray begin, stray pixel, query
          case ($urandom_range(3))
            0: it = mk(REQ_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            1: it = mk(REQ_BEGIN, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            2: it = mk(REQ_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: it = rand_query(big);
          endcase
          send_item(it);
          if (it.req_type != REQ_NONE) n_sent++;
        end
      end
    end
    quiet = 1'b0;

    drain();
    repeat (100) @(posedge clk);
    if (n_errors == 0 && window_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (window_q.size() != 0) report("results never delivered", 0, window_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
